### src/seu8_pkg.sv
// shared types, codes and helper functions for the escape decoder
package seu8_pkg;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  localparam logic [15:0] CAP_RESET = 16'd4096;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LC_X   = 8'h78;
  localparam logic [7:0] CH_LC_U   = 8'h75;
  localparam logic [7:0] CH_UC_U   = 8'h55;

  typedef enum logic [3:0] {
    ST_OK         = 4'd0,
    ST_NO_SPACE   = 4'd1,
    ST_EARLY_END  = 4'd2,
    ST_BAD_HEX    = 4'd3,
    ST_NO_LOW     = 4'd4,
    ST_BAD_LOW    = 4'd5,
    ST_LONE_LOW   = 4'd6,
    ST_BAD_CP     = 4'd7,
    ST_UNK_ESC    = 4'd8
  } status_t;

  // one accepted byte's worth of results: up to four data bytes plus end info
  typedef struct packed {
    logic [2:0]      nbytes;
    logic [3:0][7:0] data;
    logic            done;
    status_t         status;
  } job_t;

  // returns {is_hex, value}
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end
    return r;
  endfunction

  // control byte for a single-letter escape, zero if the letter has none
  function automatic logic [7:0] ctl_code(input logic [7:0] b);
    logic [7:0] r;
    unique case (b)
      8'h6E:   r = 8'h0A;
      8'h61:   r = 8'h07;
      8'h62:   r = 8'h08;
      8'h66:   r = 8'h0C;
      8'h72:   r = 8'h0D;
      8'h74:   r = 8'h09;
      8'h76:   r = 8'h0B;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

### src/seu8_ifs.sv
// valid/ready channel interfaces for the input bytes and the decoded results
interface seu8_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface seu8_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       done_res;
  logic [3:0] status;

  modport source (output valid, output out_byte, output byte_valid, output done_res,
                  output status, input ready);
  modport sink   (input valid, input out_byte, input byte_valid, input done_res,
                  input status, output ready);
endinterface

### src/string_escape_to_utf8_decoder.sv
// top level of the escape-sequence to utf-8 decoder
//
//   channel   direction  handshake        payload
//   in_ch     in         valid/ready      in_byte[7:0], in_last
//   out_ch    out        valid/ready      out_byte[7:0], byte_valid, done_res, status[3:0]
//   cfg_*     in         cfg_we (no wait) cfg_wdata[15:0] = output_capacity
//
// one input byte can transfer every cycle while the four-entry job queue has room
// each byte yields zero to four results, sent one per cycle by the serializer while out_ch is ready
// the first result passes through the job queue, the work register and the output register;
// output stalls fill the queue
// reset is synchronous and active low; no clearing pass
module string_escape_to_utf8_decoder import seu8_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  seu8_in_if.sink       in_ch,
  seu8_out_if.source    out_ch,
  input  logic          cfg_we,
  input  logic [15:0]   cfg_wdata
);

  logic q_push;
  job_t q_job;
  logic q_full;
  logic q_pop;
  job_t q_head;
  logic q_nonempty;

  seu8_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (q_job)
  );

  seu8_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_job),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head),
    .nonempty (q_nonempty)
  );

  seu8_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_nonempty (q_nonempty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_ch     (out_ch)
  );

endmodule

### src/seu8_front.sv
// parser: accepts input bytes, tracks escape state and builds at most one job per byte
module seu8_front import seu8_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  seu8_in_if.sink       in_ch,
  input  logic          cfg_we,
  input  logic [15:0]   cfg_wdata,
  input  logic          q_full,
  output logic          q_push,
  output job_t          q_job
);

  typedef enum logic [7:0] {
    MD_NORMAL  = 8'b0000_0001,
    MD_ESC     = 8'b0000_0010,
    MD_HEX_X   = 8'b0000_0100,
    MD_HEX_U   = 8'b0000_1000,
    MD_HEX_BU  = 8'b0001_0000,
    MD_HEX_LO  = 8'b0010_0000,
    MD_WANT_BS = 8'b0100_0000,
    MD_WANT_U  = 8'b1000_0000
  } mode_t;

  mode_t       mode_r, mode_nxt;
  logic [3:0]  digits_r, digits_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [9:0]  hs_r, hs_nxt;
  logic [15:0] nwr_r, nwr_nxt;
  logic        disc_r, disc_nxt;
  logic [15:0] cap_r;

  logic            fire;
  logic [7:0]      b;
  logic            last;
  logic            fin;
  status_t         fst;
  logic [2:0]      pn;
  logic [3:0][7:0] pdata;
  logic            do_cp;
  logic [20:0]     cp;
  logic [2:0]      cp_len;
  logic [3:0][7:0] cp_enc;
  logic [4:0]      hd;
  logic [7:0]      ctl;
  logic [31:0]     acc_new;
  logic [3:0]      dl;
  logic [15:0]     v16;
  logic [16:0]     need_plain;
  logic [16:0]     need_cp;

  assign in_ch.ready = !q_full;
  assign fire        = in_ch.valid && in_ch.ready;
  assign b           = in_ch.in_byte;
  assign last        = in_ch.in_last;

  assign hd      = hex_digit(b);
  assign ctl     = ctl_code(b);
  assign acc_new = {acc_r[27:0], hd[3:0]};
  assign dl      = digits_r - 4'd1;
  assign v16     = acc_new[15:0];

  assign need_plain = {1'b0, nwr_r} + 17'd1;
  assign need_cp    = {1'b0, nwr_r} + {14'd0, cp_len};

  // utf-8 length and byte pattern of the selected code point
  always_comb begin
    cp_enc = '0;
    if (cp <= 21'h7F) begin
      cp_len    = 3'd1;
      cp_enc[0] = {1'b0, cp[6:0]};
    end else if (cp <= 21'h7FF) begin
      cp_len    = 3'd2;
      cp_enc[0] = {3'b110, cp[10:6]};
      cp_enc[1] = {2'b10, cp[5:0]};
    end else if (cp <= 21'hFFFF) begin
      cp_len    = 3'd3;
      cp_enc[0] = {4'b1110, cp[15:12]};
      cp_enc[1] = {2'b10, cp[11:6]};
      cp_enc[2] = {2'b10, cp[5:0]};
    end else begin
      cp_len    = 3'd4;
      cp_enc[0] = {5'b11110, cp[20:18]};
      cp_enc[1] = {2'b10, cp[17:12]};
      cp_enc[2] = {2'b10, cp[11:6]};
      cp_enc[3] = {2'b10, cp[5:0]};
    end
  end

  always_comb begin
    mode_nxt   = mode_r;
    digits_nxt = digits_r;
    acc_nxt    = acc_r;
    hs_nxt     = hs_r;
    disc_nxt   = disc_r;
    fin        = 1'b0;
    fst        = ST_OK;
    pn         = 3'd0;
    pdata      = '0;
    do_cp      = 1'b0;
    cp         = '0;

    if (disc_r) begin
      if (last) begin
        disc_nxt = 1'b0;
      end
    end else begin
      unique case (mode_r)
        MD_NORMAL: begin
          if (b == CH_NUL) begin
            fin = 1'b1;
          end else if (need_plain >= {1'b0, cap_r}) begin
            fin = 1'b1;
            fst = ST_NO_SPACE;
          end else if (b == CH_BSLASH) begin
            if (last) begin
              fin = 1'b1;
              fst = ST_EARLY_END;
            end else begin
              mode_nxt = MD_ESC;
            end
          end else begin
            pn       = 3'd1;
            pdata[0] = b;
            fin      = last;
          end
        end
        MD_ESC: begin
          if (b == CH_NUL) begin
            fin = 1'b1;
            fst = ST_EARLY_END;
          end else if (ctl != 8'h00) begin
            pn       = 3'd1;
            pdata[0] = ctl;
            mode_nxt = MD_NORMAL;
            fin      = last;
          end else if (b == CH_LC_X || b == CH_LC_U || b == CH_UC_U) begin
            acc_nxt = '0;
            if (b == CH_LC_X) begin
              mode_nxt   = MD_HEX_X;
              digits_nxt = 4'd2;
            end else if (b == CH_LC_U) begin
              mode_nxt   = MD_HEX_U;
              digits_nxt = 4'd4;
            end else begin
              mode_nxt   = MD_HEX_BU;
              digits_nxt = 4'd8;
            end
            if (last) begin
              fin = 1'b1;
              fst = ST_EARLY_END;
            end
          end else begin
            // unknown escape: the letter goes out, then the string ends
            pn       = 3'd1;
            pdata[0] = b;
            fin      = 1'b1;
            fst      = ST_UNK_ESC;
          end
        end
        MD_HEX_X, MD_HEX_U, MD_HEX_BU, MD_HEX_LO: begin
          if (!hd[4]) begin
            fin = 1'b1;
            fst = ST_BAD_HEX;
          end else begin
            acc_nxt    = acc_new;
            digits_nxt = dl;
            if (dl != 4'd0) begin
              if (last) begin
                fin = 1'b1;
                fst = ST_EARLY_END;
              end
            end else if (mode_r == MD_HEX_X) begin
              pn       = 3'd1;
              pdata[0] = acc_new[7:0];
              mode_nxt = MD_NORMAL;
              fin      = last;
            end else if (mode_r == MD_HEX_U) begin
              if (v16 >= 16'hD800 && v16 <= 16'hDBFF) begin
                hs_nxt = v16[9:0];
                if (last) begin
                  fin = 1'b1;
                  fst = ST_NO_LOW;
                end else begin
                  mode_nxt = MD_WANT_BS;
                end
              end else if (v16 >= 16'hDC00 && v16 <= 16'hDFFF) begin
                fin = 1'b1;
                fst = ST_LONE_LOW;
              end else begin
                do_cp = 1'b1;
                cp    = {5'd0, v16};
              end
            end else if (mode_r == MD_HEX_LO) begin
              if (v16 < 16'hDC00 || v16 > 16'hDFFF) begin
                fin = 1'b1;
                fst = ST_BAD_LOW;
              end else begin
                do_cp = 1'b1;
                cp    = 21'h10000 + {1'b0, hs_r, v16[9:0]};
              end
            end else begin
              if (acc_new > 32'h0010_FFFF ||
                  (acc_new >= 32'h0000_D800 && acc_new <= 32'h0000_DFFF)) begin
                fin = 1'b1;
                fst = ST_BAD_CP;
              end else begin
                do_cp = 1'b1;
                cp    = acc_new[20:0];
              end
            end
          end
        end
        MD_WANT_BS: begin
          if (b != CH_BSLASH || last) begin
            fin = 1'b1;
            fst = ST_NO_LOW;
          end else begin
            mode_nxt = MD_WANT_U;
          end
        end
        MD_WANT_U: begin
          if (b != CH_LC_U) begin
            fin = 1'b1;
            fst = ST_NO_LOW;
          end else begin
            mode_nxt   = MD_HEX_LO;
            digits_nxt = 4'd4;
            acc_nxt    = '0;
            if (last) begin
              fin = 1'b1;
              fst = ST_EARLY_END;
            end
          end
        end
        default: begin
          mode_nxt = MD_NORMAL;
        end
      endcase

      if (do_cp) begin
        if (need_cp >= {1'b0, cap_r}) begin
          fin = 1'b1;
          fst = ST_NO_SPACE;
        end else begin
          pn       = cp_len;
          pdata    = cp_enc;
          mode_nxt = MD_NORMAL;
          fin      = last;
        end
      end

      if (fin) begin
        disc_nxt = !last;
      end
    end

    nwr_nxt = nwr_r + {13'd0, pn};
    if (fin) begin
      mode_nxt   = MD_NORMAL;
      digits_nxt = '0;
      acc_nxt    = '0;
      hs_nxt     = '0;
      nwr_nxt    = '0;
    end
  end

  assign q_push       = fire && !disc_r && (pn != 3'd0 || fin);
  assign q_job.nbytes = pn;
  assign q_job.data   = pdata;
  assign q_job.done   = fin;
  assign q_job.status = fin ? fst : ST_OK;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MD_NORMAL;
      digits_r <= '0;
      acc_r    <= '0;
      hs_r     <= '0;
      nwr_r    <= '0;
      disc_r   <= 1'b0;
    end else if (fire) begin
      mode_r   <= mode_nxt;
      digits_r <= digits_nxt;
      acc_r    <= acc_nxt;
      hs_r     <= hs_nxt;
      nwr_r    <= nwr_nxt;
      disc_r   <= disc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_we) begin
      cap_r <= cfg_wdata;
    end
  end

  a_push_needs_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> fire && !q_full)
    else $error("job pushed without an input transfer");

  a_discard_no_job: assert property (@(posedge clk) disable iff (!rst_n)
    disc_r |-> !q_push)
    else $error("job pushed while discarding");

  a_status_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    q_push && !q_job.done |-> q_job.status == ST_OK && q_job.nbytes != 3'd0)
    else $error("status or empty job without end of string");

  a_end_resets_count: assert property (@(posedge clk) disable iff (!rst_n)
    q_push && q_job.done |=> nwr_r == 16'd0 && mode_r == MD_NORMAL)
    else $error("parser state not cleared after end of string");

endmodule

### src/seu8_fifo.sv
// small job queue between the parser and the output serializer
module seu8_fifo import seu8_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output job_t head,
  output logic nonempty
);

  job_t                 mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_r;
  logic [FIFO_AW-1:0]   rd_ptr_r;
  logic [FIFO_CW-1:0]   cnt_r;
  logic                 do_push;
  logic                 do_pop;

  assign full     = (cnt_r == FIFO_CW'(FIFO_DEPTH));
  assign nonempty = (cnt_r != '0);
  assign head     = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + FIFO_AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + FIFO_AW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + FIFO_CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - FIFO_CW'(1);
      end
    end
  end

endmodule

### src/seu8_back.sv
// serializer: walks each job and presents one result per output transfer
module seu8_back import seu8_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_nonempty,
  input  job_t        q_head,
  output logic        q_pop,
  seu8_out_if.source  out_ch
);

  job_t       work_r;
  logic       work_v_r;
  logic [1:0] idx_r;
  logic       out_v_r;
  logic [7:0] out_byte_r;
  logic       out_bv_r;
  logic       out_done_r;
  status_t    out_st_r;

  logic       adv;
  logic       item_last;
  logic       has_data;
  logic       emit;

  assign adv       = !out_v_r || out_ch.ready;
  assign has_data  = (work_r.nbytes != 3'd0);
  assign item_last = !has_data || ({1'b0, idx_r} == work_r.nbytes - 3'd1);
  assign emit      = adv && work_v_r;
  assign q_pop     = q_nonempty && (!work_v_r || (emit && item_last));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      work_v_r <= 1'b0;
      idx_r    <= '0;
    end else begin
      if (q_pop) begin
        work_v_r <= 1'b1;
        idx_r    <= '0;
      end else if (emit) begin
        if (item_last) begin
          work_v_r <= 1'b0;
        end else begin
          idx_r <= idx_r + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      work_r <= q_head;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= work_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte_r <= has_data ? work_r.data[idx_r] : 8'h00;
      out_bv_r   <= has_data;
      out_done_r <= item_last && work_r.done;
      out_st_r   <= item_last ? work_r.status : ST_OK;
    end
  end

  assign out_ch.valid      = out_v_r;
  assign out_ch.out_byte   = out_byte_r;
  assign out_ch.byte_valid = out_bv_r;
  assign out_ch.done_res   = out_done_r;
  assign out_ch.status     = out_st_r;

  a_job_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    work_v_r |-> (has_data || work_r.done) && work_r.nbytes <= 3'd4)
    else $error("held job has no result to give");

  a_empty_item_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_bv_r |-> out_done_r)
    else $error("result without data byte that does not end the string");

  a_status_on_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_done_r |-> out_st_r == ST_OK)
    else $error("nonzero status before the end of the string");

endmodule
